// ===== design/bucketed_tuple_set_macros.svh =====
// Assertion macros shared by the checker of the bucketed tuple set.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef BUCKETED_TUPLE_SET_MACROS_SVH
`define BUCKETED_TUPLE_SET_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/bts_pkg.sv =====
// Package of the bucketed tuple set: payload structs, codes, state type and widths.
// Used by every module of the block; depends on nothing.
package bts_pkg;

    localparam int NUM_BUCKETS_DEF = 256;
    localparam int CAPACITY_DEF    = 8;

    localparam int BUCKET_IN_W = 8;
    localparam int BKT_TABLE   = 2 ** BUCKET_IN_W;
    localparam int REGION_W    = 8;
    localparam int SUBREGION_W = 8;
    localparam int PARTICLE_W  = 20;
    localparam int KEY_W       = REGION_W + SUBREGION_W + PARTICLE_W;
    localparam int OUT_CNT_W   = 4;

    typedef enum logic [1:0] {
        KIND_ERASE         = 2'd0,
        KIND_INSERT_UNIQUE = 2'd1,
        KIND_INSERT_FAST   = 2'd2,
        KIND_NONE          = 2'd3
    } op_kind_t;

    typedef enum logic [1:0] {
        ST_DONE         = 2'd0,
        ST_PRESENT      = 2'd1,
        ST_FULL         = 2'd2,
        ST_NONE_ERASED  = 2'd3
    } status_t;

    typedef struct packed {
        op_kind_t                kind;
        logic [BUCKET_IN_W-1:0]  bucket;
        logic [REGION_W-1:0]     region;
        logic [SUBREGION_W-1:0]  subregion;
        logic [PARTICLE_W-1:0]   particle;
    } in_item_t;

    typedef struct packed {
        status_t                status;
        logic [OUT_CNT_W-1:0]   removed;
        logic [OUT_CNT_W-1:0]   count_after;
    } out_item_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_SCAN,
        S_APPEND,
        S_FINISH
    } state_t;

    function automatic int idx_width(input int depth);
        return (depth > 1) ? $clog2(depth) : 1;
    endfunction

endpackage

// ===== design/bts_entry_store.sv =====
// Entry memory of the bucketed tuple set: one write port, one registered read port.
// Depends on bts_pkg for the key width.
module bts_entry_store #(
    parameter int DEPTH  = bts_pkg::NUM_BUCKETS_DEF * bts_pkg::CAPACITY_DEF,
    parameter int ADDR_W = bts_pkg::idx_width(DEPTH)
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [ADDR_W-1:0]        waddr,
    input  logic [bts_pkg::KEY_W-1:0] wdata,
    input  logic [ADDR_W-1:0]        raddr,
    output logic [bts_pkg::KEY_W-1:0] rdata
);
    import bts_pkg::*;

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/bts_count_store.sv =====
// Bucket count memory with a clearing sweep after reset.
// Depends on bts_pkg for the width helper.
module bts_count_store #(
    parameter int NUM_BUCKETS = bts_pkg::NUM_BUCKETS_DEF,
    parameter int CAPACITY    = bts_pkg::CAPACITY_DEF
) (
    input  logic                                      aclk,
    input  logic                                      aresetn,
    input  logic                                      we,
    input  logic [bts_pkg::idx_width(NUM_BUCKETS)-1:0] waddr,
    input  logic [$clog2(CAPACITY+1)-1:0]             wdata,
    input  logic [bts_pkg::idx_width(NUM_BUCKETS)-1:0] raddr,
    output logic [$clog2(CAPACITY+1)-1:0]             rdata,
    output logic                                      clear_busy
);
    import bts_pkg::*;

    localparam int BKT_W = idx_width(NUM_BUCKETS);
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0] mem [NUM_BUCKETS];
    logic [CNT_W-1:0] rdata_reg;
    logic             clear_reg;
    logic             clear_next;
    logic [BKT_W-1:0] clr_addr_reg;
    logic [BKT_W-1:0] clr_addr_next;
    logic             mem_we;
    logic [BKT_W-1:0] mem_waddr;
    logic [CNT_W-1:0] mem_wdata;

    always_comb begin
        clear_next    = clear_reg;
        clr_addr_next = clr_addr_reg;
        if (clear_reg) begin
            if (clr_addr_reg == BKT_W'(NUM_BUCKETS - 1)) begin
                clear_next = 1'b0;
            end else begin
                clr_addr_next = clr_addr_reg + BKT_W'(1);
            end
        end
        mem_we    = clear_reg || we;
        mem_waddr = clear_reg ? clr_addr_reg : waddr;
        mem_wdata = clear_reg ? '0 : wdata;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clear_reg    <= 1'b1;
            clr_addr_reg <= '0;
        end else begin
            clear_reg    <= clear_next;
            clr_addr_reg <= clr_addr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata      = rdata_reg;
    assign clear_busy = clear_reg;

endmodule

// ===== design/bts_ctrl.sv =====
// Sequencer of the bucketed tuple set: reads a bucket's count, walks its entries,
// compacts or appends, writes the count back and holds the result register.
// Depends on bts_pkg.
module bts_ctrl #(
    parameter int NUM_BUCKETS = bts_pkg::NUM_BUCKETS_DEF,
    parameter int CAPACITY    = bts_pkg::CAPACITY_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  bts_pkg::in_item_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output bts_pkg::out_item_t         m_data,
    input  logic                       clear_busy,
    output logic [bts_pkg::idx_width(NUM_BUCKETS)-1:0] cnt_raddr,
    input  logic [$clog2(CAPACITY+1)-1:0]              cnt_rdata,
    output logic                                       cnt_we,
    output logic [bts_pkg::idx_width(NUM_BUCKETS)-1:0] cnt_waddr,
    output logic [$clog2(CAPACITY+1)-1:0]              cnt_wdata,
    output logic [bts_pkg::idx_width(NUM_BUCKETS)+bts_pkg::idx_width(CAPACITY)-1:0] ent_raddr,
    input  logic [bts_pkg::KEY_W-1:0]                  ent_rdata,
    output logic                                       ent_we,
    output logic [bts_pkg::idx_width(NUM_BUCKETS)+bts_pkg::idx_width(CAPACITY)-1:0] ent_waddr,
    output logic [bts_pkg::KEY_W-1:0]                  ent_wdata
);
    import bts_pkg::*;

    localparam int BKT_W  = idx_width(NUM_BUCKETS);
    localparam int SLOT_W = idx_width(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);

    logic [BKT_W-1:0] bkt_map [BKT_TABLE];

    for (genvar i = 0; i < BKT_TABLE; i++) begin : g_bkt_map
        assign bkt_map[i] = BKT_W'(i % NUM_BUCKETS);
    end

    state_t           state_reg, state_next;
    op_kind_t         kind_reg, kind_next;
    logic [BKT_W-1:0] bkt_reg, bkt_next;
    logic [KEY_W-1:0] key_reg, key_next;
    logic [CNT_W-1:0] n_reg, n_next;
    logic [CNT_W-1:0] rd_reg, rd_next;
    logic [CNT_W-1:0] wr_reg, wr_next;
    logic [CNT_W-1:0] removed_reg, removed_next;
    status_t          status_reg, status_next;
    logic             out_valid_reg, out_valid_next;
    out_item_t        out_data_reg, out_data_next;

    logic             accept;
    logic             match;
    logic [CNT_W-1:0] rd_inc;
    logic [CNT_W-1:0] wr_after;
    logic [CNT_W-1:0] removed_after;
    logic             out_free;

    assign accept        = s_valid && s_ready;
    assign match         = (ent_rdata == key_reg);
    assign rd_inc        = rd_reg + CNT_W'(1);
    assign wr_after      = match ? wr_reg : wr_reg + CNT_W'(1);
    assign removed_after = match ? removed_reg + CNT_W'(1) : removed_reg;
    assign out_free      = !out_valid_reg || m_ready;

    always_comb begin
        state_next     = state_reg;
        kind_next      = kind_reg;
        bkt_next       = bkt_reg;
        key_next       = key_reg;
        n_next         = n_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        removed_next   = removed_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_data_next  = out_data_reg;
        s_ready        = 1'b0;
        cnt_raddr      = bkt_map[s_data.bucket];
        cnt_we         = 1'b0;
        cnt_waddr      = bkt_reg;
        cnt_wdata      = n_reg;
        ent_raddr      = {bkt_reg, rd_inc[SLOT_W-1:0]};
        ent_we         = 1'b0;
        ent_waddr      = {bkt_reg, wr_reg[SLOT_W-1:0]};
        ent_wdata      = ent_rdata;

        unique case (state_reg)
            S_IDLE: begin
                s_ready = !clear_busy;
                if (accept) begin
                    kind_next  = s_data.kind;
                    bkt_next   = bkt_map[s_data.bucket];
                    key_next   = {s_data.region, s_data.subregion, s_data.particle};
                    state_next = S_COUNT;
                end
            end
            S_COUNT: begin
                n_next       = cnt_rdata;
                rd_next      = '0;
                wr_next      = '0;
                removed_next = '0;
                status_next  = ST_DONE;
                ent_raddr    = {bkt_reg, {SLOT_W{1'b0}}};
                unique case (kind_reg)
                    KIND_ERASE: begin
                        if (cnt_rdata == '0) begin
                            status_next = ST_NONE_ERASED;
                            state_next  = S_FINISH;
                        end else begin
                            state_next = S_SCAN;
                        end
                    end
                    KIND_INSERT_UNIQUE: begin
                        state_next = (cnt_rdata == '0) ? S_APPEND : S_SCAN;
                    end
                    KIND_INSERT_FAST: begin
                        state_next = S_APPEND;
                    end
                    KIND_NONE: begin
                        status_next = ST_NONE_ERASED;
                        state_next  = S_FINISH;
                    end
                endcase
            end
            S_SCAN: begin
                rd_next = rd_inc;
                if (kind_reg == KIND_ERASE) begin
                    ent_we       = !match;
                    wr_next      = wr_after;
                    removed_next = removed_after;
                    if (rd_inc == n_reg) begin
                        n_next      = wr_after;
                        status_next = (removed_after != '0) ? ST_DONE : ST_NONE_ERASED;
                        state_next  = S_FINISH;
                    end
                end else begin
                    priority if (match) begin
                        status_next = ST_PRESENT;
                        state_next  = S_FINISH;
                    end else if (rd_inc == n_reg) begin
                        state_next = S_APPEND;
                    end else begin
                        state_next = S_SCAN;
                    end
                end
            end
            S_APPEND: begin
                if (n_reg == CNT_W'(CAPACITY)) begin
                    status_next = ST_FULL;
                end else begin
                    ent_we      = 1'b1;
                    ent_waddr   = {bkt_reg, n_reg[SLOT_W-1:0]};
                    ent_wdata   = key_reg;
                    n_next      = n_reg + CNT_W'(1);
                    status_next = ST_DONE;
                end
                state_next = S_FINISH;
            end
            S_FINISH: begin
                cnt_we = 1'b1;
                if (out_free) begin
                    out_valid_next            = 1'b1;
                    out_data_next.status      = status_reg;
                    out_data_next.removed     = OUT_CNT_W'(removed_reg);
                    out_data_next.count_after = OUT_CNT_W'(n_reg);
                    state_next                = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        bkt_reg      <= bkt_next;
        key_reg      <= key_next;
        n_reg        <= n_next;
        rd_reg       <= rd_next;
        wr_reg       <= wr_next;
        removed_reg  <= removed_next;
        status_reg   <= status_next;
        out_data_reg <= out_data_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule

// ===== design/bucketed_tuple_set.sv =====
// Bucketed tuple set: each bucket holds an ordered list of particle triples.
// A request names a bucket, a triple and a kind: erase every match (later entries
// move down), insert if absent, or insert without search. Each request returns
// one result with a status, the number of entries removed and the bucket's count.
// Requests arrive on s_valid/s_ready/s_data and results leave on m_valid/m_ready/m_data.
// A request passes through the idle state in which it is accepted, the count read, one
// scan step per stored entry walked for a search or an erase, an append and the count
// write-back. The shortest path (unused kind, or erase of an empty bucket) skips the walk
// and the append; the longest (insert if absent into a full bucket without a match) walks
// every entry and then tries the append. The result is loaded into the output register
// at write-back.
// After reset the bucket counts are swept to zero, one bucket per cycle; s_ready is low
// during the sweep. Entry contents are not cleared.
// A stalled receiver holds the result in the output register; the next request
// may be accepted meanwhile and then waits at write-back until the register frees.
// Depends on bts_pkg, bts_ctrl, bts_count_store and bts_entry_store.
module bucketed_tuple_set #(
    parameter int NUM_BUCKETS = bts_pkg::NUM_BUCKETS_DEF,
    parameter int CAPACITY    = bts_pkg::CAPACITY_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  bts_pkg::in_item_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output bts_pkg::out_item_t m_data
);
    import bts_pkg::*;

    localparam int BKT_W   = idx_width(NUM_BUCKETS);
    localparam int SLOT_W  = idx_width(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int ENT_AW  = BKT_W + SLOT_W;
    localparam int ENT_DEP = NUM_BUCKETS * (2 ** SLOT_W);

    logic              clear_busy;
    logic [BKT_W-1:0]  cnt_raddr;
    logic [CNT_W-1:0]  cnt_rdata;
    logic              cnt_we;
    logic [BKT_W-1:0]  cnt_waddr;
    logic [CNT_W-1:0]  cnt_wdata;
    logic [ENT_AW-1:0] ent_raddr;
    logic [KEY_W-1:0]  ent_rdata;
    logic              ent_we;
    logic [ENT_AW-1:0] ent_waddr;
    logic [KEY_W-1:0]  ent_wdata;

    bts_ctrl #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .CAPACITY    (CAPACITY)
    ) u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .clear_busy (clear_busy),
        .cnt_raddr  (cnt_raddr),
        .cnt_rdata  (cnt_rdata),
        .cnt_we     (cnt_we),
        .cnt_waddr  (cnt_waddr),
        .cnt_wdata  (cnt_wdata),
        .ent_raddr  (ent_raddr),
        .ent_rdata  (ent_rdata),
        .ent_we     (ent_we),
        .ent_waddr  (ent_waddr),
        .ent_wdata  (ent_wdata)
    );

    bts_count_store #(
        .NUM_BUCKETS (NUM_BUCKETS),
        .CAPACITY    (CAPACITY)
    ) u_count_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .we         (cnt_we),
        .waddr      (cnt_waddr),
        .wdata      (cnt_wdata),
        .raddr      (cnt_raddr),
        .rdata      (cnt_rdata),
        .clear_busy (clear_busy)
    );

    bts_entry_store #(
        .DEPTH  (ENT_DEP),
        .ADDR_W (ENT_AW)
    ) u_entry_store (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (ent_raddr),
        .rdata (ent_rdata)
    );

endmodule

// ===== design/bts_checker.sv =====
// Port-level checker of the bucketed tuple set and its bind to the top level.
// Depends on bts_pkg and bucketed_tuple_set_macros.svh.
`include "bucketed_tuple_set_macros.svh"

module bts_checker (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input bts_pkg::out_item_t m_data
);
    import bts_pkg::*;

    logic [1:0] pending_reg;
    logic [1:0] pending_next;
    logic       s_take;
    logic       m_take;
    logic       m_stall;
    logic       not_done;

    assign s_take   = s_valid && s_ready;
    assign m_take   = m_valid && m_ready;
    assign m_stall  = m_valid && !m_ready;
    assign not_done = m_valid && (m_data.status != ST_DONE);

    always_comb begin
        pending_next = pending_reg;
        if (s_take && !m_take) begin
            pending_next = pending_reg + 2'd1;
        end else if (m_take && !s_take) begin
            pending_next = pending_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else begin
            pending_reg <= pending_next;
        end
    end

    `BTS_ASSERT_NEXT(a_result_held, aclk, aresetn, m_stall, m_valid && $stable(m_data),
                     "Stalled result changed or vanished.")
    `BTS_ASSERT_NOW(a_no_invented_result, aclk, aresetn, m_valid, pending_reg != 2'd0,
                    "Result shown without an outstanding request.")
    `BTS_ASSERT_NOW(a_sweep_after_reset, aclk, aresetn, $past(!aresetn), !s_ready,
                    "Request taken before the count sweep.")
    `BTS_ASSERT_NOW(a_removed_only_done, aclk, aresetn, not_done, m_data.removed == '0,
                    "Entries removed with a non-done status.")

endmodule

bind bucketed_tuple_set bts_checker u_bts_checker (.*);
